[hw/rtl/oflal_pkg.sv]
package oflal_pkg;

  // Default sizes of the identifier space and of a stored object reference.
  localparam int unsigned MAX_HANDLES_DEF = 256;
  localparam int unsigned REF_WIDTH_DEF   = 32;

  // Fixed widths of the transfer fields.
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned HANDLE_IN_W  = 9;
  localparam int unsigned HANDLE_OUT_W = 8;
  localparam int unsigned REF_IO_W     = 32;
  localparam int unsigned STATUS_W     = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ID    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [HANDLE_IN_W-1:0] handle_in;
    logic [REF_IO_W-1:0]    object_ref_in;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_OUT_W-1:0] handle_out;
    logic [REF_IO_W-1:0]     object_ref_out;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

endpackage

[hw/rtl/oflal_ram.sv]
// Simple dual-port memory: one write port, one read port with registered data.
module oflal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/object_id_free_list_allocator_core.sv]
// Identifier allocator built on a linked free list. Each transfer carries one
// command: allocate pops the head of the free list, records the object
// reference under that identifier and returns it (status "none free" when the
// list is empty); release checks that the identifier is in range and in use,
// clears its entry and pushes it back as the new head (status "bad
// identifier" otherwise, with no change of state); lookup returns the stored
// reference, or zero for a null entry or an identifier out of range. Every
// command gives exactly one result transfer. Each command runs in two steps:
// the first reads the link memory and the object memory, the second forms the
// result and writes both memories back; no new command is taken before then.
// A finished result sits in an output register; the next command is taken in
// the same cycle that this result is taken. No clearing pass is needed after
// reset: a fill count marks the identifiers that have never been handed out,
// whose entries read as empty and whose links point at the next identifier.
module object_id_free_list_allocator_core #(
  parameter int unsigned MaxHandles = oflal_pkg::MAX_HANDLES_DEF,
  parameter int unsigned RefWidth   = oflal_pkg::REF_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  oflal_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output oflal_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW  = $clog2(MaxHandles);
  localparam int unsigned LinkW = $clog2(MaxHandles + 1);
  localparam int unsigned ObjW  = RefWidth + 1;

  // Two-step sequencer: idle (waiting for a command) and execute.
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  // Head of the free list, and the count of identifiers ever handed out.
  // Identifiers at or above the fill count are fresh: never written, so their
  // object entry is null and not in use, and their link is the identifier
  // plus one. The free list is always the released identifiers followed by
  // the fresh ones in ascending order.
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] fill_q, fill_d;

  oflal_pkg::in_item_t  req_q;
  logic                 out_valid_q, out_valid_d;
  oflal_pkg::out_item_t out_data_q, out_data_d;

  logic accept;
  logic out_free;

  // Memory ports.
  logic             link_we;
  logic [IdxW-1:0]  link_waddr;
  logic [LinkW-1:0] link_wdata;
  logic [IdxW-1:0]  link_raddr;
  logic [LinkW-1:0] link_rdata;
  logic             obj_we;
  logic [IdxW-1:0]  obj_waddr;
  logic [ObjW-1:0]  obj_wdata;
  logic [IdxW-1:0]  obj_raddr;
  logic [ObjW-1:0]  obj_rdata;

  // Address helpers.
  logic [31:0] in_hid_wide;
  logic [31:0] req_hid_wide;
  logic [31:0] head_wide;
  logic [63:0] ref_in_wide;
  logic [63:0] ref_rd_wide;

  // Execute-step decode.
  logic             hid_in_range;
  logic             hid_known;
  logic             hid_used;
  logic             list_has_free;
  logic             head_fresh;
  logic [LinkW-1:0] next_head;

  // A command is taken only while idle and while the output register is free
  // or being emptied at this very edge, so the execute step always has room
  // for its result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && (state_q == StIdle) && out_free;
  assign in_stall_o = (state_q != StIdle) || !out_free;

  assign in_hid_wide  = 32'(in_data_i.handle_in);
  assign req_hid_wide = 32'(req_q.handle_in);
  assign head_wide    = 32'(head_q);
  assign ref_in_wide  = 64'(req_q.object_ref_in);
  assign ref_rd_wide  = 64'(obj_rdata[RefWidth-1:0]);

  // Reads are issued at the edge that takes the command; the data is ready
  // in the execute step. Writes happen only in the execute step, and no read
  // is issued then, so the two never overlap on one entry.
  assign link_raddr = head_wide[IdxW-1:0];
  assign obj_raddr  = in_hid_wide[IdxW-1:0];

  assign hid_in_range  = req_hid_wide < 32'(MaxHandles);
  assign hid_known     = hid_in_range && (req_hid_wide < 32'(fill_q));
  assign hid_used      = hid_known && obj_rdata[RefWidth];
  assign list_has_free = head_wide < 32'(MaxHandles);
  assign head_fresh    = head_q >= fill_q;
  assign next_head     = head_fresh ? LinkW'(head_wide + 32'd1) : link_rdata;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    link_we     = 1'b0;
    link_waddr  = req_hid_wide[IdxW-1:0];
    link_wdata  = head_q;
    obj_we      = 1'b0;
    obj_waddr   = req_hid_wide[IdxW-1:0];
    obj_wdata   = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d                   = StIdle;
        out_valid_d               = 1'b1;
        out_data_d.handle_out     = req_q.handle_in[oflal_pkg::HANDLE_OUT_W-1:0];
        out_data_d.object_ref_out = '0;
        out_data_d.status         = oflal_pkg::ST_OK;
        unique case (req_q.cmd)
          oflal_pkg::CMD_ALLOC: begin
            if (list_has_free) begin
              // Pop the head and record the reference with its in-use mark.
              obj_we                = 1'b1;
              obj_waddr             = head_wide[IdxW-1:0];
              obj_wdata             = {1'b1, ref_in_wide[RefWidth-1:0]};
              head_d                = next_head;
              out_data_d.handle_out = head_wide[oflal_pkg::HANDLE_OUT_W-1:0];
              if (head_fresh) begin
                fill_d = LinkW'(head_wide + 32'd1);
              end
            end else begin
              out_data_d.status = oflal_pkg::ST_NONE_FREE;
            end
          end
          oflal_pkg::CMD_RELEASE: begin
            if (hid_used) begin
              // Clear the entry and push the identifier onto the list.
              obj_we  = 1'b1;
              link_we = 1'b1;
              head_d  = LinkW'(req_hid_wide);
            end else begin
              out_data_d.status = oflal_pkg::ST_BAD_ID;
            end
          end
          oflal_pkg::CMD_LOOKUP: begin
            if (hid_known) begin
              out_data_d.object_ref_out = ref_rd_wide[oflal_pkg::REF_IO_W-1:0];
            end
          end
          default: begin
            // The unused command changes nothing and reports success.
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    out_data_q <= out_data_d;
  end

  oflal_ram #(
    .Width (LinkW),
    .Depth (MaxHandles)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (accept),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  oflal_ram #(
    .Width (ObjW),
    .Depth (MaxHandles)
  ) u_obj_ram (
    .clk_i   (clk_i),
    .we_i    (obj_we),
    .waddr_i (obj_waddr),
    .wdata_i (obj_wdata),
    .re_i    (accept),
    .raddr_i (obj_raddr),
    .rdata_o (obj_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
